/* src/itoa_pkg.sv */
// Shared types, constants and a helper function for the integer-to-ASCII radix formatter.
package itoa_pkg;

	localparam int VALUE_W    = 32;
	localparam int IN_VALUE_W = 32;
	localparam int DIG_MAX    = VALUE_W;
	localparam int OCT_D      = (VALUE_W + 2) / 3;
	localparam int HEX_D      = (VALUE_W + 3) / 4;
	localparam int DEC_D      = (VALUE_W * 301) / 1000 + 1;
	localparam int PTR_W      = $clog2(DIG_MAX);
	localparam int CNT_W      = $clog2(VALUE_W + 1);
	localparam int ADDR_W     = 3;

	localparam logic [1:0] RADIX_BIN = 2'd0;
	localparam logic [1:0] RADIX_OCT = 2'd1;
	localparam logic [1:0] RADIX_DEC = 2'd2;
	localparam logic [1:0] RADIX_HEX = 2'd3;
	localparam logic [1:0] RADIX_RESET = RADIX_DEC;

	localparam logic REG_RADIX_SELECT = 1'b0;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_A     = 8'h41;

	typedef enum logic [1:0] {
		MODE_RAW      = 2'd0,
		MODE_UNSIGNED = 2'd1,
		MODE_SIGNED   = 2'd2,
		MODE_POINTER  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t                   mode;
		logic [IN_VALUE_W-1:0]   value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic               load;
		logic               xfer;
		logic               skip;
		logic               pop;
		logic [1:0]         radix;
		logic [VALUE_W-1:0] mag;
	} dig_ctl_t;

	typedef struct packed {
		logic [3:0] digit;
		logic       msd_zero;
		logic       at_lsd;
		logic       conv_done;
	} dig_stat_t;

	function automatic logic [7:0] digit_char(logic [3:0] d);
		if (d < 4'd10) begin
			return CH_ZERO + {4'b0, d};
		end
		return CH_A + {4'b0, d} - 8'd10;
	endfunction

endpackage

/* src/itoa_digit_unit.sv */
// Digit store with a shared shift-and-add-3 converter and a digit pointer.
module itoa_digit_unit import itoa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dig_ctl_t  ctl,
	output dig_stat_t stat
);

	logic [3:0]           dig_q [DIG_MAX];
	logic [PTR_W-1:0]     ptr_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [VALUE_W-1:0]   bin_q;
	logic [4*DEC_D-1:0]   bcd_q;
	logic [4*DEC_D-1:0]   bcd_adj;
	logic [3:0]           bcd_dig;
	logic [3*DIG_MAX-1:0] ext3;
	logic [4*DIG_MAX-1:0] ext4;

	assign ext3 = {{(2*VALUE_W){1'b0}}, ctl.mag};
	assign ext4 = {{(3*VALUE_W){1'b0}}, ctl.mag};

	always_comb begin
		bcd_adj = bcd_q;
		bcd_dig = 4'd0;
		for (int k = 0; k < DEC_D; k++) begin
			bcd_dig = bcd_q[4*k +: 4];
			bcd_adj[4*k +: 4] = (bcd_dig >= 4'd5) ? bcd_dig + 4'd3 : bcd_dig;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			bin_q <= ctl.mag;
			bcd_q <= '0;
			for (int k = 0; k < DIG_MAX; k++) begin
				case (ctl.radix)
					RADIX_BIN: dig_q[k] <= {3'b0, ctl.mag[k]};
					RADIX_OCT: dig_q[k] <= {1'b0, ext3[3*k +: 3]};
					RADIX_HEX: dig_q[k] <= ext4[4*k +: 4];
					default:   dig_q[k] <= 4'd0;
				endcase
			end
		end else if (ctl.xfer) begin
			for (int k = 0; k < DEC_D; k++) begin
				dig_q[k] <= bcd_q[4*k +: 4];
			end
		end else if (cnt_q != '0) begin
			{bcd_q, bin_q} <= {bcd_adj[4*DEC_D-2:0], bin_q, 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			cnt_q <= '0;
		end else if (ctl.load) begin
			case (ctl.radix)
				RADIX_BIN: begin
					ptr_q <= PTR_W'(DIG_MAX - 1);
					cnt_q <= '0;
				end
				RADIX_OCT: begin
					ptr_q <= PTR_W'(OCT_D - 1);
					cnt_q <= '0;
				end
				RADIX_HEX: begin
					ptr_q <= PTR_W'(HEX_D - 1);
					cnt_q <= '0;
				end
				default: begin
					ptr_q <= '0;
					cnt_q <= CNT_W'(VALUE_W);
				end
			endcase
		end else if (ctl.xfer) begin
			ptr_q <= PTR_W'(DEC_D - 1);
		end else if (ctl.skip || ctl.pop) begin
			ptr_q <= ptr_q - 1'b1;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign stat.digit     = dig_q[ptr_q];
	assign stat.msd_zero  = (dig_q[ptr_q] == 4'd0);
	assign stat.at_lsd    = (ptr_q == '0);
	assign stat.conv_done = (cnt_q == '0);

endmodule

/* src/integer_to_ascii_radix_formatter.sv */
// Top level of the integer-to-ASCII radix formatter: command port, register port, sequencer.
//
// Usage: a token is offered on item with start; it is taken as a transaction
// at a clock edge where start is high and busy is low. Each output character
// appears on result for exactly one cycle with strobe high; result.last marks
// the final character of the token. The receiver cannot stall the block, so
// characters leave back to back at one per cycle once digits are ready.
// A raw-byte token gives its character in the next cycle and busy stays low,
// so raw tokens can be taken on every cycle.
// A number token raises busy from the accepting edge until the cycle that shows
// its last character. Decimal first converts with 32 shift-and-add-3 steps and
// one transfer. Every number then drops its leading zero digits one at a time and
// finds the first digit, then forms any sign or prefix character and then each
// digit; each character is registered and shows in the cycle after it is formed.
// No new token is taken while busy, so the next token waits until a number is done.
// All conversion and digit stepping use one shared digit unit, one step per cycle.
// The radix register sits at byte address 0 of the register port and must be
// written only while the block is idle; the block itself does not enforce this.
// Reset sets radix to decimal, clears the sequencer and drops strobe; no
// transaction is in flight afterwards.
module integer_to_ascii_radix_formatter import itoa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  in_item_t          item,
	output logic              strobe,
	output out_item_t         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CONV  = 7'b0000010,
		S_SKIP  = 7'b0000100,
		S_SIGN  = 7'b0001000,
		S_PFX0  = 7'b0010000,
		S_PFXX  = 7'b0100000,
		S_DIGIT = 7'b1000000
	} state_t;

	state_t             state_q;
	logic [1:0]         radix_q;
	logic [1:0]         rad_q;
	logic               neg_q;
	logic               strobe_q;
	out_item_t          result_q;
	dig_ctl_t           ctl;
	dig_stat_t          stat;
	logic               accept;
	logic [VALUE_W-1:0] val;
	logic               is_neg;
	logic [1:0]         eff_radix;

	itoa_digit_unit u_digit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.stat   (stat)
	);

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_RADIX_SELECT) ? {30'b0, radix_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_RADIX_SELECT) begin
			radix_q <= pwdata[1:0];
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign val    = item.value[VALUE_W-1:0];
	assign is_neg = (item.mode == MODE_SIGNED) && val[VALUE_W-1];
	assign eff_radix = (item.mode == MODE_POINTER) ? RADIX_HEX : radix_q;

	always_comb begin
		ctl       = '0;
		ctl.radix = eff_radix;
		ctl.mag   = is_neg ? (~val + 1'b1) : val;
		ctl.load  = accept && (item.mode != MODE_RAW);
		ctl.xfer  = (state_q == S_CONV) && stat.conv_done;
		ctl.skip  = (state_q == S_SKIP) && stat.msd_zero && !stat.at_lsd;
		ctl.pop   = (state_q == S_DIGIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
			rad_q    <= RADIX_RESET;
			neg_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.mode == MODE_RAW) begin
							strobe_q <= 1'b1;
						end else begin
							rad_q   <= eff_radix;
							neg_q   <= is_neg;
							state_q <= (eff_radix == RADIX_DEC) ? S_CONV : S_SKIP;
						end
					end
				end
				S_CONV: begin
					if (stat.conv_done) begin
						state_q <= S_SKIP;
					end
				end
				S_SKIP: begin
					if (!(stat.msd_zero && !stat.at_lsd)) begin
						if (neg_q) begin
							state_q <= S_SIGN;
						end else if (rad_q == RADIX_OCT || rad_q == RADIX_HEX) begin
							state_q <= S_PFX0;
						end else begin
							state_q <= S_DIGIT;
						end
					end
				end
				S_SIGN: begin
					strobe_q <= 1'b1;
					if (rad_q == RADIX_OCT || rad_q == RADIX_HEX) begin
						state_q <= S_PFX0;
					end else begin
						state_q <= S_DIGIT;
					end
				end
				S_PFX0: begin
					strobe_q <= 1'b1;
					state_q  <= (rad_q == RADIX_HEX) ? S_PFXX : S_DIGIT;
				end
				S_PFXX: begin
					strobe_q <= 1'b1;
					state_q  <= S_DIGIT;
				end
				S_DIGIT: begin
					strobe_q <= 1'b1;
					if (stat.at_lsd) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				result_q.char_out <= item.value[7:0];
				result_q.last     <= 1'b1;
			end
			S_SIGN: begin
				result_q.char_out <= CH_MINUS;
				result_q.last     <= 1'b0;
			end
			S_PFX0: begin
				result_q.char_out <= CH_ZERO;
				result_q.last     <= 1'b0;
			end
			S_PFXX: begin
				result_q.char_out <= CH_X;
				result_q.last     <= 1'b0;
			end
			S_DIGIT: begin
				result_q.char_out <= digit_char(stat.digit);
				result_q.last     <= stat.at_lsd;
			end
			default: begin
				result_q <= result_q;
			end
		endcase
	end

	assign strobe = strobe_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_last_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |-> !busy)
		else $error("Block still busy while the final character is shown.");

	a_number_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.mode != MODE_RAW) |=> busy)
		else $error("Number transaction accepted but the block did not go busy.");

	a_conv_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CONV || state_q == S_SKIP) |=> !strobe)
		else $error("A character was shown during conversion or zero skipping.");

	a_skip_stops_at_lsd: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.skip |-> !stat.at_lsd)
		else $error("Leading-zero skip passed the least significant digit.");
`endif

endmodule
